### sv/sfr_pkg.sv
// sfr_pkg: shared types and constants for the stream find-and-replace block
// no dependencies; used by every other file of the block but sfr_stream_if

package sfr_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned LEN_CFG_W  = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIND_LEN        = 2'd0,
    REG_FIND_PATTERN    = 2'd1,
    REG_REPLACE_LEN     = 2'd2,
    REG_REPLACE_PATTERN = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              char_valid;
    logic              string_end;
    logic              run_last;
  } out_item_t;

  typedef struct packed {
    logic en;
    logic shift;
  } win_ctl_t;

  typedef struct packed {
    logic load;
    logic pop;
  } out_ctl_t;

endpackage

### sv/sfr_stream_if.sv
// sfr_stream_if: valid/ready channel carrying one payload item per transaction
// payload type is supplied per instance, normally from sfr_pkg

interface sfr_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/sfr_win_cell.sv
// sfr_win_cell: one byte of the pending match window with its pattern compare
// depends on sfr_pkg (win_ctl_t, CHAR_W)

module sfr_win_cell (
  input  logic                      clk,
  input  sfr_pkg::win_ctl_t         ctl,
  input  logic                      ins,
  input  logic [sfr_pkg::CHAR_W-1:0] in_char,
  input  logic [sfr_pkg::CHAR_W-1:0] right_v,
  input  logic [sfr_pkg::CHAR_W-1:0] pat,
  output logic [sfr_pkg::CHAR_W-1:0] v,
  output logic                      eq
);

  logic [sfr_pkg::CHAR_W-1:0] byte_r;
  logic [sfr_pkg::CHAR_W-1:0] byte_nxt;

  // window content with the incoming byte placed at the fill position
  always_comb begin
    v        = ins ? in_char : byte_r;
    eq       = (v == pat);
    byte_nxt = ctl.shift ? right_v : v;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      byte_r <= byte_nxt;
    end
  end

endmodule

### sv/sfr_out_cell.sv
// sfr_out_cell: one slot of the result shift chain, head slot feeds the output
// depends on sfr_pkg (out_ctl_t, CHAR_W)

module sfr_out_cell (
  input  logic                      clk,
  input  sfr_pkg::out_ctl_t         ctl,
  input  logic [sfr_pkg::CHAR_W-1:0] load_byte,
  input  logic [sfr_pkg::CHAR_W-1:0] right_byte,
  output logic [sfr_pkg::CHAR_W-1:0] byte_o
);

  logic [sfr_pkg::CHAR_W-1:0] byte_r;
  logic [sfr_pkg::CHAR_W-1:0] byte_nxt;

  always_comb begin
    if (ctl.load) begin
      byte_nxt = load_byte;
    end else if (ctl.pop) begin
      byte_nxt = right_byte;
    end else begin
      byte_nxt = byte_r;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_o = byte_r;

endmodule

### sv/stream_find_replace.sv
// stream_find_replace: streaming byte find-and-replace over a chain of window cells
// depends on sfr_pkg, sfr_stream_if, sfr_win_cell, sfr_out_cell
//
//   channel   dir  payload                                      handshake
//   in_ch     in   in_char, in_last                             valid/ready
//   out_ch    out  out_char, char_valid, string_end, run_last   valid/ready
//   cfg_*     in   cfg_index, cfg_data                          cfg_we, no wait
//
// a byte is matched against the window in the cycle it is taken; its results
// load the output chain at that edge and leave one per cycle from the head cell
// a byte yielding several results keeps in_ready low until only its last is left and
// out_ready is high; bytes yielding at most one result stream at one per cycle while
// out_ready is high; rst_n is synchronous; no clearing pass, the block is ready right
// after reset; out_ready low holds the head result and blocks input once a result waits

module stream_find_replace #(
  parameter int unsigned FIND_MAX    = 8,
  parameter int unsigned REPLACE_MAX = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  sfr_stream_if.sink                       in_ch,
  sfr_stream_if.source                     out_ch,
  input  logic                             cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned CW  = sfr_pkg::CHAR_W;
  localparam int unsigned FLW = $clog2(FIND_MAX + 1);
  localparam int unsigned RLW = $clog2(REPLACE_MAX + 1);
  localparam int unsigned QD  = (FIND_MAX > REPLACE_MAX) ? FIND_MAX : REPLACE_MAX;
  localparam int unsigned QCW = $clog2(QD + 1);

  // configuration
  logic [FLW-1:0]            flen_r;
  logic [FIND_MAX*CW-1:0]    find_pat_r;
  logic [RLW-1:0]            rlen_r;
  logic [REPLACE_MAX*CW-1:0] rep_pat_r;
  logic [sfr_pkg::LEN_CFG_W-1:0] cfg_len;

  // window and result chain state
  logic [FLW-1:0] count_r;
  logic [FLW-1:0] count_nxt;
  logic [QCW-1:0] qcnt_r;
  logic [QCW-1:0] qcnt_nxt;
  logic           bare_r;
  logic           last_r;

  logic            in_fire;
  logic            pop;
  logic            full;
  logic            match;
  logic            hit;
  logic            bare_new;
  logic [QCW-1:0]  n_calc;
  logic [QCW-1:0]  n_new;
  logic [FIND_MAX-1:0] eq;
  logic [FIND_MAX-1:0] mask;
  logic [CW-1:0]   win_v [FIND_MAX];
  logic [CW-1:0]   q_load [QD];
  logic [CW-1:0]   q_byte [QD];

  sfr_pkg::win_ctl_t win_ctl;
  sfr_pkg::out_ctl_t out_ctl;
  sfr_pkg::in_item_t in_item;
  sfr_pkg::out_item_t out_item;

  assign in_item = in_ch.data;
  assign cfg_len = cfg_data[sfr_pkg::LEN_CFG_W-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flen_r     <= FLW'(1);
      find_pat_r <= '0;
      rlen_r     <= '0;
      rep_pat_r  <= '0;
    end else if (cfg_we) begin
      case (sfr_pkg::cfg_reg_t'(cfg_index))
        sfr_pkg::REG_FIND_LEN: begin
          if (cfg_len == '0) begin
            flen_r <= FLW'(1);
          end else if (cfg_len > sfr_pkg::LEN_CFG_W'(FIND_MAX)) begin
            flen_r <= FLW'(FIND_MAX);
          end else begin
            flen_r <= FLW'(cfg_len);
          end
        end
        sfr_pkg::REG_FIND_PATTERN: begin
          find_pat_r <= cfg_data[FIND_MAX*CW-1:0];
        end
        sfr_pkg::REG_REPLACE_LEN: begin
          if (cfg_len > sfr_pkg::LEN_CFG_W'(REPLACE_MAX)) begin
            rlen_r <= RLW'(REPLACE_MAX);
          end else begin
            rlen_r <= RLW'(cfg_len);
          end
        end
        sfr_pkg::REG_REPLACE_PATTERN: begin
          rep_pat_r <= cfg_data[REPLACE_MAX*CW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // handshake
  assign pop         = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (qcnt_r == '0) || ((qcnt_r == QCW'(1)) && out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // window cells
  genvar k;
  generate
    for (k = 0; k < FIND_MAX; k++) begin : g_win
      logic [CW-1:0] right_v;
      if (k == FIND_MAX - 1) begin : g_end
        assign right_v = '0;
      end else begin : g_mid
        assign right_v = win_v[k+1];
      end
      assign mask[k] = (FLW'(k) < flen_r);
      sfr_win_cell u_cell (
        .clk     (clk),
        .ctl     (win_ctl),
        .ins     (count_r == FLW'(k)),
        .in_char (in_item.in_char),
        .right_v (right_v),
        .pat     (find_pat_r[k*CW +: CW]),
        .v       (win_v[k]),
        .eq      (eq[k])
      );
    end
  endgenerate

  assign full  = (count_r == FLW'(flen_r - FLW'(1)));
  assign match = &(eq | ~mask);
  assign hit   = full && match;

  always_comb begin
    win_ctl.en    = in_fire;
    win_ctl.shift = full && !match;
  end

  always_comb begin
    count_nxt = count_r;
    if (in_fire) begin
      if (in_item.in_last || hit) begin
        count_nxt = '0;
      end else if (!full) begin
        count_nxt = FLW'(count_r + FLW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we && (sfr_pkg::cfg_reg_t'(cfg_index) == sfr_pkg::REG_FIND_LEN)) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // results of the accepted byte
  always_comb begin
    if (hit) begin
      n_calc = QCW'(rlen_r);
    end else if (in_item.in_last) begin
      n_calc = QCW'(QCW'(count_r) + QCW'(1));
    end else if (full) begin
      n_calc = QCW'(1);
    end else begin
      n_calc = '0;
    end
    bare_new = in_item.in_last && (n_calc == '0);
    n_new    = bare_new ? QCW'(1) : n_calc;
  end

  generate
    for (k = 0; k < QD; k++) begin : g_load
      logic [CW-1:0] rep_b;
      logic [CW-1:0] win_b;
      if (k < REPLACE_MAX) begin : g_rep
        assign rep_b = rep_pat_r[k*CW +: CW];
      end else begin : g_norep
        assign rep_b = '0;
      end
      if (k < FIND_MAX) begin : g_w
        assign win_b = win_v[k];
      end else begin : g_now
        assign win_b = '0;
      end
      assign q_load[k] = hit ? rep_b : win_b;
    end
  endgenerate

  // result chain
  always_comb begin
    out_ctl.load = in_fire;
    out_ctl.pop  = pop;
  end

  generate
    for (k = 0; k < QD; k++) begin : g_out
      logic [CW-1:0] right_b;
      if (k == QD - 1) begin : g_end
        assign right_b = '0;
      end else begin : g_mid
        assign right_b = q_byte[k+1];
      end
      sfr_out_cell u_cell (
        .clk        (clk),
        .ctl        (out_ctl),
        .load_byte  (q_load[k]),
        .right_byte (right_b),
        .byte_o     (q_byte[k])
      );
    end
  endgenerate

  always_comb begin
    qcnt_nxt = qcnt_r;
    if (in_fire) begin
      qcnt_nxt = n_new;
    end else if (pop) begin
      qcnt_nxt = QCW'(qcnt_r - QCW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= '0;
      bare_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      qcnt_r <= qcnt_nxt;
      if (in_fire) begin
        bare_r <= bare_new;
        last_r <= in_item.in_last;
      end
    end
  end

  always_comb begin
    out_item.out_char   = bare_r ? '0 : q_byte[0];
    out_item.char_valid = !bare_r;
    out_item.run_last   = (qcnt_r == QCW'(1));
    out_item.string_end = last_r && (qcnt_r == QCW'(1));
  end

  assign out_ch.valid = (qcnt_r != '0);
  assign out_ch.data  = out_item;

endmodule

### sv/sfr_checker.sv
// sfr_checker: port-level checks for stream_find_replace, attached by bind
// depends on the top level's port names and sfr_pkg widths

module sfr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sfr_pkg::CHAR_W-1:0] out_char,
  input logic                       char_valid,
  input logic                       string_end,
  input logic                       run_last
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(char_valid)
      && $stable(string_end) && $stable(run_last))
    else $error("result changed while stalled");

  // bare end marker carries no byte and closes the string
  a_bare: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !char_valid |-> string_end && run_last && (out_char == '0))
    else $error("malformed end marker");

  a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && string_end |-> run_last)
    else $error("string end without run end");

  // input only backs up behind a pending result
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked with no result pending");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_char   (out_ch.data.out_char),
  .char_valid (out_ch.data.char_valid),
  .string_end (out_ch.data.string_end),
  .run_last   (out_ch.data.run_last)
);

### sim/sfr_rewrite_checker.sv
`timescale 1ns / 1ps
// sfr_rewrite_checker: predicts the rewritten byte stream of stream_find_replace and
// compares every output transaction; watches both channels and the register port
// depends on sfr_pkg

module sfr_rewrite_checker #(
  parameter int unsigned FIND_MAX    = 8,
  parameter int unsigned REPLACE_MAX = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  sfr_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  sfr_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             err_count,
  output int                             pending,
  output int                             n_in,
  output int                             n_out,
  output int                             n_hits
);

  logic [sfr_pkg::LEN_CFG_W-1:0]  find_len;
  logic [sfr_pkg::LEN_CFG_W-1:0]  replace_len;
  logic [sfr_pkg::CFG_DATA_W-1:0] find_pat;
  logic [sfr_pkg::CFG_DATA_W-1:0] replace_pat;
  logic [sfr_pkg::CHAR_W-1:0]     win [FIND_MAX];
  int unsigned                    win_cnt;
  sfr_pkg::out_item_t             expected_chars [$];
  int                             errors;
  int                             accepted;
  int                             checked;
  int                             hits;

  function automatic void shift_window(input int unsigned n);
    for (int i = 0; i < FIND_MAX; i++)
      win[i] = (i + n < FIND_MAX) ? win[i + n] : '0;
    win_cnt = (n >= win_cnt) ? 0 : win_cnt - n;
  endfunction

  function automatic void rewrite_char(input sfr_pkg::in_item_t it);
    logic [sfr_pkg::CHAR_W-1:0] chars [$];
    int unsigned                flen;
    int unsigned                rlen;
    logic                       hit;
    flen = (find_len == 0) ? 1 : ((find_len > FIND_MAX) ? FIND_MAX : find_len);
    rlen = (replace_len > REPLACE_MAX) ? REPLACE_MAX : replace_len;
    if (win_cnt < FIND_MAX) begin
      win[win_cnt] = it.in_char;
      win_cnt++;
    end
    if (win_cnt >= flen) begin
      hit = 1'b1;
      for (int k = 0; k < flen; k++)
        if (win[k] != find_pat[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        hits++;
        for (int k = 0; k < rlen; k++) chars.push_back(replace_pat[8*k +: 8]);
        shift_window(flen);
      end else begin
        chars.push_back(win[0]);
        shift_window(1);
      end
    end
    if (it.in_last) begin
      for (int k = 0; k < win_cnt; k++) chars.push_back(win[k]);
      shift_window(FIND_MAX);
    end
    if (chars.size() == 0) begin
      // end of string with nothing left: bare end marker
      if (it.in_last)
        expected_chars.push_back('{out_char: '0, char_valid: 1'b0, string_end: 1'b1,
                                   run_last: 1'b1});
    end else begin
      foreach (chars[k])
        expected_chars.push_back('{out_char: chars[k], char_valid: 1'b1,
                                   string_end: it.in_last && (k == chars.size() - 1),
                                   run_last: k == chars.size() - 1});
    end
  endfunction

  function automatic void cmp_field(input string name,
                                    input logic [sfr_pkg::CHAR_W-1:0] want,
                                    input logic [sfr_pkg::CHAR_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(input sfr_pkg::out_item_t got);
    sfr_pkg::out_item_t want;
    checked++;
    if (expected_chars.size() == 0) begin
      $display("%0t: unexpected transaction, expected none, actual char %0h valid %0b",
               $time, got.out_char, got.char_valid);
      $display("%0t: actual end %0b last %0b", $time, got.string_end, got.run_last);
      errors++;
    end else begin
      want = expected_chars.pop_front();
      cmp_field("out_char", want.out_char, got.out_char);
      cmp_field("char_valid", sfr_pkg::CHAR_W'(want.char_valid),
                sfr_pkg::CHAR_W'(got.char_valid));
      cmp_field("string_end", sfr_pkg::CHAR_W'(want.string_end),
                sfr_pkg::CHAR_W'(got.string_end));
      cmp_field("run_last", sfr_pkg::CHAR_W'(want.run_last),
                sfr_pkg::CHAR_W'(got.run_last));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      find_len    = sfr_pkg::LEN_CFG_W'(1);
      find_pat    = '0;
      replace_len = '0;
      replace_pat = '0;
      win_cnt     = FIND_MAX;
      shift_window(FIND_MAX);
      expected_chars.delete();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) begin
        accepted++;
        rewrite_char(in_data);
      end
      if (cfg_we) begin
        case (sfr_pkg::cfg_reg_t'(cfg_index))
          sfr_pkg::REG_FIND_LEN: begin
            find_len = cfg_data[sfr_pkg::LEN_CFG_W-1:0];
            shift_window(FIND_MAX);
          end
          sfr_pkg::REG_FIND_PATTERN:    find_pat    = cfg_data;
          sfr_pkg::REG_REPLACE_LEN:     replace_len = cfg_data[sfr_pkg::LEN_CFG_W-1:0];
          sfr_pkg::REG_REPLACE_PATTERN: replace_pat = cfg_data;
          default: ;
        endcase
      end
    end
    err_count <= errors;
    pending   <= expected_chars.size();
    n_in      <= accepted;
    n_out     <= checked;
    n_hits    <= hits;
  end

endmodule

### sim/tb_stream_find_replace.sv
`timescale 1ns / 1ps
// tb_stream_find_replace: testbench top; drives byte strings, register writes and
// output back-pressure, and reports the verdict from sfr_rewrite_checker
// depends on sfr_pkg, sfr_stream_if, stream_find_replace, sfr_rewrite_checker

module tb_stream_find_replace;

  localparam int unsigned RAND_ITEMS  = 210;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 24;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef logic [sfr_pkg::CHAR_W-1:0] text_t [$];

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  sfr_pkg::cfg_reg_t              cfg_index;
  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           tx_idle;
  logic                           rx_idle;
  logic                           hold_out;
  int unsigned                    cycle_cnt;
  int unsigned                    rule_sets;
  int                             err_count;
  int                             pending;
  int                             n_in;
  int                             n_out;
  int                             n_hits;

  sfr_stream_if #(.payload_t(sfr_pkg::in_item_t))  in_ch ();
  sfr_stream_if #(.payload_t(sfr_pkg::out_item_t)) out_ch ();

  stream_find_replace dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sfr_rewrite_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .err_count (err_count),
    .pending   (pending),
    .n_in      (n_in),
    .n_out     (n_out),
    .n_hits    (n_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_cnt,
               pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // output side: random stalls, plus one long hold on request
  initial begin : rx_proc
    int unsigned stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 18) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid && !hold_out);
    end
  end

  task automatic send_char(input logic [sfr_pkg::CHAR_W-1:0] c, input logic l);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{in_char: c, in_last: l};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_text(input text_t s, input logic close);
    foreach (s[k]) send_char(s[k], close && (k == s.size() - 1));
  endtask

  // wait until every expected transaction is out, then let the block go quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input sfr_pkg::cfg_reg_t idx,
                         input logic [sfr_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_rules(input logic [sfr_pkg::LEN_CFG_W-1:0] fl,
                           input logic [sfr_pkg::CFG_DATA_W-1:0] fp,
                           input logic [sfr_pkg::LEN_CFG_W-1:0] rl,
                           input logic [sfr_pkg::CFG_DATA_W-1:0] rp);
    put_reg(sfr_pkg::REG_FIND_LEN, sfr_pkg::CFG_DATA_W'(fl));
    put_reg(sfr_pkg::REG_FIND_PATTERN, fp);
    put_reg(sfr_pkg::REG_REPLACE_LEN, sfr_pkg::CFG_DATA_W'(rl));
    put_reg(sfr_pkg::REG_REPLACE_PATTERN, rp);
    cfg_we <= 1'b0;
    rule_sets++;
  endtask

  // mostly whole or broken copies of the pattern, some plain noise
  task automatic make_text(input logic [sfr_pkg::LEN_CFG_W-1:0] fl,
                           input logic [sfr_pkg::CFG_DATA_W-1:0] fp,
                           output text_t s);
    int unsigned fe;
    int unsigned kind;
    int unsigned cut;
    s  = {};
    fe = (fl == 0) ? 1 : ((fl > 8) ? 8 : fl);
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 10)) s.push_back(sfr_pkg::CHAR_W'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          for (int k = 0; k < fe; k++) s.push_back(fp[8*k +: 8]);
        end else if (kind < 7) begin
          cut = $urandom_range(0, fe - 1);
          for (int k = 0; k < cut; k++) s.push_back(fp[8*k +: 8]);
          s.push_back(sfr_pkg::CHAR_W'($urandom));
        end else if (kind == 7) begin
          s.push_back(fp[8*$urandom_range(0, fe - 1) +: 8]);
        end else begin
          s.push_back(sfr_pkg::CHAR_W'($urandom));
        end
      end
    end
  endtask

  initial begin : stim
    text_t                          s;
    logic [sfr_pkg::LEN_CFG_W-1:0]  fl;
    logic [sfr_pkg::LEN_CFG_W-1:0]  rl;
    logic [sfr_pkg::CFG_DATA_W-1:0] fp;
    logic [sfr_pkg::CFG_DATA_W-1:0] rp;
    int unsigned                    n_rand;
    int unsigned                    budget;
    int unsigned                    phase;

    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= sfr_pkg::REG_FIND_LEN;
    cfg_data    <= '0;
    rst_n       <= 1'b0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    hold_out    = 1'b0;
    rule_sets   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset rules: zero byte is deleted, leaving only the end marker
    send_text('{8'h00}, 1'b1);
    send_text('{8'hff}, 1'b1);
    drain();

    // longest pattern, longest replacement
    fp = 64'hff00_5aa5_f00f_7e81;
    set_rules(4'd8, fp, 4'd8, 64'hffff_ffff_ffff_ffff);
    s = {};
    for (int k = 0; k < 8; k++) s.push_back(fp[8*k +: 8]);
    send_text(s, 1'b1);
    drain();

    // zero find length acts as one, replace length above range clips, upper bytes ignored
    set_rules(4'd0, 64'hffff_ffff_ffff_ff41, 4'd15, 64'h0807_0605_0403_0201);
    send_text('{8'h41, 8'h42}, 1'b1);
    drain();

    // find length above range clips; rewriting it drops the pending bytes
    set_rules(4'd15, 64'hffff_ffff_ffff_ffff, 4'd0, 64'h0);
    send_text('{8'hff, 8'hff, 8'hff}, 1'b0);
    drain();
    put_reg(sfr_pkg::REG_FIND_LEN, 64'd2);
    cfg_we <= 1'b0;
    send_text('{8'h00}, 1'b1);
    drain();

    // repeated byte pattern: matches do not overlap
    set_rules(4'd2, 64'hdead_beef_0000_6161, 4'd1, 64'h62);
    send_text('{8'h61, 8'h61, 8'h61, 8'h61, 8'h61}, 1'b1);
    drain();

    set_rules(4'd3, 64'h7a79_78, 4'd9, 64'h0123_4567_89ab_cdef);
    send_text('{8'h78, 8'h79, 8'h7a}, 1'b1);

    n_rand = 0;
    phase  = 0;
    while (n_rand < RAND_ITEMS) begin
      drain();
      fl = ($urandom_range(0, 3) == 0) ? sfr_pkg::LEN_CFG_W'($urandom_range(0, 15))
                                       : sfr_pkg::LEN_CFG_W'($urandom_range(1, 4));
      rl = ($urandom_range(0, 3) == 0) ? sfr_pkg::LEN_CFG_W'($urandom_range(0, 15))
                                       : sfr_pkg::LEN_CFG_W'($urandom_range(0, 4));
      fp = {$urandom, $urandom};
      rp = {$urandom, $urandom};
      if ($urandom_range(0, 4) == 0) fp = {8{fp[7:0]}};
      set_rules(fl, fp, rl, rp);
      tx_idle = ($urandom_range(0, 2) != 0);
      rx_idle = ($urandom_range(0, 2) != 0);
      if (phase == 1) begin
        hold_out = 1'b1;
        tx_idle  = 1'b0;
      end
      budget = 0;
      while (budget < 30) begin
        make_text(fl, fp, s);
        send_text(s, 1'b1);
        budget += s.size();
      end
      n_rand += budget;
      phase++;
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);

    if (pending != 0)
      $display("%0t: %0d expected results never arrived", $time, pending);
    $display("covered %0d input bytes under %0d rule sets, %0d pattern hits",
             n_in, rule_sets, n_hits);
    $display("checked %0d output transactions, one output hold of %0d cycles",
             n_out, HOLD_CYCLES);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
sv/sfr_pkg.sv
sv/sfr_stream_if.sv
sv/sfr_win_cell.sv
sv/sfr_out_cell.sv
sv/stream_find_replace.sv
sv/sfr_checker.sv
sim/sfr_rewrite_checker.sv
sim/tb_stream_find_replace.sv
